[design/binary_delta_patch_apply_assert.svh]
// Assertion macros for the binary delta patch applier.
// Depends on nothing; the including module supplies clk and rst_n.
// Include guard: BINARY_DELTA_PATCH_APPLY_ASSERT_SVH.
`ifndef BINARY_DELTA_PATCH_APPLY_ASSERT_SVH
`define BINARY_DELTA_PATCH_APPLY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDPA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdpa: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BDPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdpa: next-cycle check failed");

`endif

[design/bdpa_pkg.sv]
// Shared types and constants for the binary delta patch applier.
// Depends on nothing; used by binary_delta_patch_apply.
`default_nettype none

package bdpa_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;
    localparam int CFG_DATA_W        = 32;
    localparam int LEN_W             = 31;
    localparam int WORD_W            = 64;
    localparam int POS_OUT_W         = 32;

    // Configuration register indexes
    localparam logic REG_OLD_SIZE = 1'b0;
    localparam logic REG_NEW_SIZE = 1'b1;

    // Control triple field order
    localparam logic [1:0] FLD_DIFF  = 2'd0;
    localparam logic [1:0] FLD_EXTRA = 2'd1;
    localparam logic [1:0] FLD_SEEK  = 2'd2;

    // Last byte of an 8-byte control field
    localparam logic [2:0] CTRL_LAST_BYTE = 3'd7;

    typedef enum logic [2:0] {
        PH_CTRL,
        PH_DIFF,
        PH_EXTRA,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]           new_byte;
        logic                 new_byte_valid;
        status_t              status;
        logic [WORD_W-1:0]    old_position;
        logic [POS_OUT_W-1:0] new_position;
    } result_t;

endpackage

`default_nettype wire

[design/binary_delta_patch_apply.sv]
// Binary delta patch applier (bsdiff-style patch stream, apply side).
// Depends on bdpa_pkg and binary_delta_patch_apply_assert.svh.
// Top level of the block.
`default_nettype none
`include "binary_delta_patch_apply_assert.svh"

// Rebuilds a new image from a decompressed patch stream, one patch byte per
// item. Each input item carries the next patch byte plus the old image byte at
// the old position reported in the previous result (old_position), so the
// upstream side must fetch that byte before offering the next item. The patch
// stream is a run of control triples (diff length, extra length, old seek),
// each an 8-byte little-endian sign-magnitude integer, followed by the diff
// bytes (added mod 256 to the old byte when the old position lies inside the
// old image) and then the extra bytes (passed as is). Every item gives exactly
// one result; new_byte_valid marks those that carry an image byte. A bad or
// overrunning length latches status ERROR, reaching new_image_size latches
// DONE; both hold until reset and later items give no image byte.
// Throughput: one item per cycle while the skid register is empty. All per-item
// work is a single pass of adders and compares from the state registers into a
// two-entry result buffer (output register plus skid register), so input is
// taken while one finished result still waits at the output.
// The user writes configuration (cfg_we/cfg_index/cfg_data) while the block is
// idle, not enforced here. Sizes are masked to CFG_W bits, read at every use.
module binary_delta_patch_apply #(
    parameter int SIZE_BITS = bdpa_pkg::SIZE_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // patch byte input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      patch_byte,
    input  wire logic [7:0]                      old_byte,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [7:0]                           new_byte,
    output logic                                 new_byte_valid,
    output logic [1:0]                           status,
    output logic signed [bdpa_pkg::WORD_W-1:0]   old_position,
    output logic [bdpa_pkg::POS_OUT_W-1:0]       new_position,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [bdpa_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Size registers keep at most 32 bits and never more than SIZE_BITS.
    localparam int CFG_W = (SIZE_BITS < bdpa_pkg::CFG_DATA_W) ? SIZE_BITS
                                                               : bdpa_pkg::CFG_DATA_W;
    // Room for new_pos plus a 31-bit length without overflow.
    localparam int SUM_W = ((SIZE_BITS > bdpa_pkg::LEN_W) ? SIZE_BITS
                                                          : bdpa_pkg::LEN_W) + 1;
    localparam int WW = bdpa_pkg::WORD_W;
    localparam int LW = bdpa_pkg::LEN_W;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [CFG_W-1:0]     old_size_reg;
    logic [CFG_W-1:0]     new_size_reg;

    bdpa_pkg::phase_t     phase_reg, phase_next, phase_eff;
    logic [2:0]           cbyte_cnt_reg, cbyte_cnt_next;
    logic [1:0]           field_idx_reg, field_idx_next;
    logic [WW-1:0]        asm_reg, asm_next;
    logic [LW-1:0]        diff_rem_reg, diff_rem_next;
    logic [LW-1:0]        extra_rem_reg, extra_rem_next;
    logic [WW-1:0]        seek_reg, seek_next;
    logic [WW-1:0]        old_pos_reg, old_pos_next;
    logic [SIZE_BITS-1:0] new_pos_reg, new_pos_next;

    logic                 accept;
    logic                 pop;

    // Result buffer: output stage and skid stage
    bdpa_pkg::result_t    out_res_reg;
    bdpa_pkg::result_t    skid_res_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    bdpa_pkg::result_t    res_next;

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic [SUM_W-1:0]     size_ext;
    logic [SUM_W-1:0]     np_ext;
    logic [SIZE_BITS-1:0] np_inc;
    logic [SUM_W-1:0]     np_inc_ext;
    logic                 np_ge_size;
    logic                 np_inc_ge_size;
    logic                 ctrl_diff_over;
    logic                 ctrl_extra_over;
    logic                 diff_extra_over;
    logic                 start_done;

    logic [WW-1:0]        full_word;
    logic [WW-1:0]        mag64;
    logic                 len_ok;
    logic [WW-1:0]        old_pos_ctrl;
    logic [WW-1:0]        old_pos_inc;
    logic [WW-1:0]        old_pos_inc_seek;
    logic [WW-1:0]        old_pos_seek;
    logic                 old_inside;

    logic [7:0]           nb_next;
    logic                 nbv_next;
    bdpa_pkg::status_t    st_next;

    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    assign size_ext       = SUM_W'(new_size_reg);
    assign np_ext         = SUM_W'(new_pos_reg);
    assign np_inc         = new_pos_reg + SIZE_BITS'(1);
    assign np_inc_ext     = SUM_W'(np_inc);
    assign np_ge_size     = np_ext >= size_ext;
    assign np_inc_ge_size = np_inc_ext >= size_ext;

    assign ctrl_diff_over  = (np_ext + SUM_W'(diff_rem_reg)) > size_ext;
    assign ctrl_extra_over = (np_ext + SUM_W'(extra_rem_reg)) > size_ext;
    assign diff_extra_over = (np_inc_ext + SUM_W'(extra_rem_reg)) > size_ext;

    // A triple may only start while bytes are still owed
    assign start_done = (phase_reg == bdpa_pkg::PH_CTRL) && (cbyte_cnt_reg == '0)
                        && (field_idx_reg == bdpa_pkg::FLD_DIFF) && np_ge_size;
    assign phase_eff  = start_done ? bdpa_pkg::PH_DONE : phase_reg;

    // Little-endian gather: place the byte at its lane
    assign full_word = asm_reg | (WW'(patch_byte) << {cbyte_cnt_reg, 3'b000});
    assign mag64     = {1'b0, full_word[WW-2:0]};

    // Non-negative (negative zero allowed) and at most 2^31-1
    assign len_ok = (full_word[WW-2:LW] == '0)
                    && (!full_word[WW-1] || (full_word[LW-1:0] == '0));

    assign old_pos_ctrl     = full_word[WW-1] ? (old_pos_reg - mag64)
                                              : (old_pos_reg + mag64);
    assign old_pos_inc      = old_pos_reg + WW'(1);
    assign old_pos_inc_seek = old_pos_reg + seek_reg + WW'(1);
    assign old_pos_seek     = old_pos_reg + seek_reg;

    assign old_inside = !old_pos_reg[WW-1] && (old_pos_reg[WW-2:CFG_W] == '0)
                        && (old_pos_reg[CFG_W-1:0] < old_size_reg);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        phase_next     = phase_eff;
        cbyte_cnt_next = cbyte_cnt_reg;
        field_idx_next = field_idx_reg;
        asm_next       = asm_reg;
        diff_rem_next  = diff_rem_reg;
        extra_rem_next = extra_rem_reg;
        seek_next      = seek_reg;
        old_pos_next   = old_pos_reg;
        new_pos_next   = new_pos_reg;

        unique case (phase_eff)
            bdpa_pkg::PH_CTRL:
            begin
                cbyte_cnt_next = cbyte_cnt_reg + 3'd1;
                if (cbyte_cnt_reg != bdpa_pkg::CTRL_LAST_BYTE)
                begin
                    asm_next = full_word;
                end
                else
                begin
                    asm_next = '0;
                    unique case (field_idx_reg)
                        bdpa_pkg::FLD_DIFF:
                        begin
                            if (!len_ok)
                            begin
                                phase_next = bdpa_pkg::PH_ERROR;
                            end
                            else
                            begin
                                diff_rem_next  = full_word[LW-1:0];
                                field_idx_next = bdpa_pkg::FLD_EXTRA;
                            end
                        end
                        bdpa_pkg::FLD_EXTRA:
                        begin
                            if (!len_ok)
                            begin
                                phase_next = bdpa_pkg::PH_ERROR;
                            end
                            else
                            begin
                                extra_rem_next = full_word[LW-1:0];
                                field_idx_next = bdpa_pkg::FLD_SEEK;
                            end
                        end
                        default:
                        begin
                            // seek field closes the triple
                            seek_next      = full_word[WW-1] ? (WW'(0) - mag64) : mag64;
                            field_idx_next = bdpa_pkg::FLD_DIFF;
                            if (ctrl_diff_over)
                            begin
                                phase_next = bdpa_pkg::PH_ERROR;
                            end
                            else if (diff_rem_reg != '0)
                            begin
                                phase_next = bdpa_pkg::PH_DIFF;
                            end
                            else if (ctrl_extra_over)
                            begin
                                phase_next = bdpa_pkg::PH_ERROR;
                            end
                            else if (extra_rem_reg != '0)
                            begin
                                phase_next = bdpa_pkg::PH_EXTRA;
                            end
                            else
                            begin
                                // empty triple: apply seek only
                                old_pos_next = old_pos_ctrl;
                                phase_next   = np_ge_size ? bdpa_pkg::PH_DONE
                                                          : bdpa_pkg::PH_CTRL;
                            end
                        end
                    endcase
                end
            end
            bdpa_pkg::PH_DIFF:
            begin
                old_pos_next  = old_pos_inc;
                new_pos_next  = np_inc;
                diff_rem_next = diff_rem_reg - LW'(1);
                if (diff_rem_reg == LW'(1))
                begin
                    if (diff_extra_over)
                    begin
                        phase_next = bdpa_pkg::PH_ERROR;
                    end
                    else if (extra_rem_reg != '0)
                    begin
                        phase_next = bdpa_pkg::PH_EXTRA;
                    end
                    else
                    begin
                        old_pos_next = old_pos_inc_seek;
                        phase_next   = np_inc_ge_size ? bdpa_pkg::PH_DONE
                                                      : bdpa_pkg::PH_CTRL;
                    end
                end
            end
            bdpa_pkg::PH_EXTRA:
            begin
                new_pos_next   = np_inc;
                extra_rem_next = extra_rem_reg - LW'(1);
                if (extra_rem_reg == LW'(1))
                begin
                    old_pos_next = old_pos_seek;
                    phase_next   = np_inc_ge_size ? bdpa_pkg::PH_DONE
                                                  : bdpa_pkg::PH_CTRL;
                end
            end
            default:
            begin
                // done and error hold everything
                phase_next = phase_eff;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result fields
    // ---------------------------------------------------------------
    always_comb
    begin
        nb_next  = 8'd0;
        nbv_next = 1'b0;
        unique case (phase_eff)
            bdpa_pkg::PH_DIFF:
            begin
                nb_next  = old_inside ? (patch_byte + old_byte) : patch_byte;
                nbv_next = 1'b1;
            end
            bdpa_pkg::PH_EXTRA:
            begin
                nb_next  = patch_byte;
                nbv_next = 1'b1;
            end
            default:
            begin
                nbv_next = 1'b0;
            end
        endcase

        unique case (phase_next)
            bdpa_pkg::PH_DONE:  st_next = bdpa_pkg::ST_DONE;
            bdpa_pkg::PH_ERROR: st_next = bdpa_pkg::ST_ERROR;
            default:            st_next = bdpa_pkg::ST_RUN;
        endcase

        res_next.new_byte       = nb_next;
        res_next.new_byte_valid = nbv_next;
        res_next.status         = st_next;
        res_next.old_position   = old_pos_next;
        res_next.new_position   = bdpa_pkg::POS_OUT_W'(new_pos_next);
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_size_reg <= '0;
            new_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdpa_pkg::REG_OLD_SIZE: old_size_reg <= cfg_data[CFG_W-1:0];
                bdpa_pkg::REG_NEW_SIZE: new_size_reg <= cfg_data[CFG_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bdpa_pkg::PH_CTRL;
            cbyte_cnt_reg <= '0;
            field_idx_reg <= bdpa_pkg::FLD_DIFF;
            asm_reg       <= '0;
            diff_rem_reg  <= '0;
            extra_rem_reg <= '0;
            seek_reg      <= '0;
            old_pos_reg   <= '0;
            new_pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            cbyte_cnt_reg <= cbyte_cnt_next;
            field_idx_reg <= field_idx_next;
            asm_reg       <= asm_next;
            diff_rem_reg  <= diff_rem_next;
            extra_rem_reg <= extra_rem_next;
            seek_reg      <= seek_next;
            old_pos_reg   <= old_pos_next;
            new_pos_reg   <= new_pos_next;
        end
    end

    // Two-entry result buffer: fill the output stage first, spill to skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= skid_valid_reg && accept;
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= accept;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg <= skid_res_reg;
                if (accept)
                begin
                    skid_res_reg <= res_next;
                end
            end
            else if (accept)
            begin
                out_res_reg <= res_next;
            end
        end
        else if (!out_valid_reg)
        begin
            if (accept)
            begin
                out_res_reg <= res_next;
            end
        end
        else if (accept)
        begin
            skid_res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign new_byte       = out_res_reg.new_byte;
    assign new_byte_valid = out_res_reg.new_byte_valid;
    assign status         = out_res_reg.status;
    assign old_position   = $signed(out_res_reg.old_position);
    assign new_position   = out_res_reg.new_position;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Error latches until reset
    `BDPA_ASSERT_NEXT(a_error_sticky, phase_reg == bdpa_pkg::PH_ERROR, phase_reg == bdpa_pkg::PH_ERROR)
    // A diff run never sits with nothing left to do
    `BDPA_ASSERT_IMPLY(a_diff_nonzero, phase_reg == bdpa_pkg::PH_DIFF, diff_rem_reg != '0)
    // Done produces no more bytes
    `BDPA_ASSERT_NEXT(a_done_holds_pos, accept && (phase_reg == bdpa_pkg::PH_DONE), $stable(new_pos_reg))
    // Skid only fills behind a held output
    `BDPA_ASSERT_IMPLY(a_skid_order, skid_valid_reg, out_valid_reg)

endmodule

`default_nettype wire
